>>> hdl/rtt_pkg.sv
// Shared types and constants for the recent tag table with age expiry.
`default_nettype none

package rtt_pkg;

  // Width of the sort key: an empty flag above a 32-bit age.
  localparam int KEY_W = 33;

  // Age limit after reset: one day in milliseconds.
  localparam logic [31:0] AGE_LIMIT_RESET = 32'(1000 * 60 * 60 * 24);

  // Operation that the sequencer broadcasts to every cell.
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_AGE,
    OP_MATCH,
    OP_UPDATE,
    OP_KEY,
    OP_SORT
  } cell_op_t;

  // Control group broadcast from the sequencer to the cells.
  typedef struct packed {
    cell_op_t    op;
    logic        phase;
    logic        miss;
    logic [31:0] now;
    logic [31:0] limit;
    logic [2:0]  tag_type;
    logic [3:0]  tag_len;
  } cell_ctrl_t;

endpackage

`default_nettype wire

>>> hdl/rtt_cell.sv
// One table slot: holds an entry, ages it, matches it and swaps with its neighbors.
`default_nettype none

module rtt_cell #(
  parameter int ID_BYTES = 10,
  parameter int IDX = 0,
  parameter int SLOTS = 8,
  localparam int ID_W = ID_BYTES * 8,
  localparam int ENT_W = 3 + ID_W + 4 + 32
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire rtt_pkg::cell_ctrl_t      ctrl,
  input  wire logic [ID_W-1:0]          tag_id,
  input  wire logic                     sel,
  input  wire logic [ENT_W-1:0]         prev_ent,
  input  wire logic [rtt_pkg::KEY_W-1:0] prev_key,
  input  wire logic                     prev_gt,
  input  wire logic [ENT_W-1:0]         next_ent,
  input  wire logic [rtt_pkg::KEY_W-1:0] next_key,
  output logic [ENT_W-1:0]              ent,
  output logic [rtt_pkg::KEY_W-1:0]     key,
  output logic                          gt_next,
  output logic                          match
);

  localparam bit HAS_PREV = (IDX > 0);
  localparam bit HAS_NEXT = (IDX < SLOTS - 1);
  localparam logic PARITY = 1'(IDX % 2);

  logic [2:0]                  type_r;
  logic [ID_W-1:0]             id_r;
  logic [3:0]                  len_r;
  logic [31:0]                 seen_r;
  logic [rtt_pkg::KEY_W-1:0]   key_r;
  logic                        match_r;

  logic [31:0]     age;
  logic            match_c;
  logic            is_left;
  logic            is_right;
  logic [ID_W-1:0] id_ins;

  assign ent     = {seen_r, len_r, id_r, type_r};
  assign key     = key_r;
  assign match   = match_r;
  assign gt_next = (key_r > next_key);
  assign age     = ctrl.now - seen_r;

  // In each sort phase a cell pairs with its next or its previous neighbor.
  assign is_left  = HAS_NEXT && (ctrl.phase == PARITY);
  assign is_right = HAS_PREV && (ctrl.phase != PARITY);

  // Type must match and every byte below the length must match.
  always_comb begin
    match_c = (type_r == ctrl.tag_type);
    for (int j = 0; j < ID_BYTES; j++) begin
      if ((4'(j) < ctrl.tag_len) && (id_r[j*8 +: 8] != tag_id[j*8 +: 8])) begin
        match_c = 1'b0;
      end
    end
  end

  // A miss replaces the bytes below the length and keeps the rest.
  always_comb begin
    id_ins = id_r;
    for (int j = 0; j < ID_BYTES; j++) begin
      if (4'(j) < ctrl.tag_len) begin
        id_ins[j*8 +: 8] = tag_id[j*8 +: 8];
      end
    end
  end

  // Entry storage, driven by the broadcast operation.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_r  <= '0;
      id_r    <= '0;
      len_r   <= '0;
      seen_r  <= '0;
      key_r   <= '0;
      match_r <= 1'b0;
    end else begin
      unique case (ctrl.op)
        rtt_pkg::OP_HOLD: begin
        end
        rtt_pkg::OP_AGE: begin
          if (age > ctrl.limit) begin
            type_r <= '0;
            id_r   <= '0;
            len_r  <= '0;
            seen_r <= '0;
          end
        end
        rtt_pkg::OP_MATCH: begin
          match_r <= match_c;
        end
        rtt_pkg::OP_UPDATE: begin
          if (sel) begin
            seen_r <= ctrl.now;
          end else if (!HAS_NEXT && ctrl.miss) begin
            id_r   <= id_ins;
            len_r  <= ctrl.tag_len;
            type_r <= ctrl.tag_type;
            seen_r <= ctrl.now;
          end
        end
        rtt_pkg::OP_KEY: begin
          key_r <= {seen_r == 32'd0, ctrl.now - seen_r};
        end
        rtt_pkg::OP_SORT: begin
          if (is_left && gt_next) begin
            {seen_r, len_r, id_r, type_r} <= next_ent;
            key_r <= next_key;
          end else if (is_right && prev_gt) begin
            {seen_r, len_r, id_r, type_r} <= prev_ent;
            key_r <= prev_key;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/recent_tag_table_aging.sv
// Top level of the recent tag table: sequencer, row of slot cells and result register.
//
// Input transfers carry one command each: in_tuser = 0 is a detect (aging, then
// lookup, refresh or insert, then re-sort), in_tuser = 1 reads one table slot.
// Every command produces exactly one result transfer on the out_ channel.
// A detect walks the row of cells through aging, match, update and key steps,
// then TABLE_SLOTS odd-even transposition phases in which neighboring cells
// swap entries; the result is then registered in the output state. A detect
// with a zero id length only ages the table and goes straight to the output
// state; a read goes straight to the output state as well.
// The block works on one command at a time; in_tready is high while idle.
// The result sits in an output register, so a stalled receiver does not stop
// the next command from being accepted and worked on; only the hand-over of
// the following result waits for out_tready.
// cfg_we writes the age limit; the user writes it only while idle, the block does not enforce it.
// Reset empties the table at once and sets the age limit to one day.
`default_nettype none

module recent_tag_table_aging #(
  parameter int TABLE_SLOTS = 8,
  parameter int ID_BYTES = 10
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // in_tdata, from bit 0: now_ms[32], tag_type[3], tag_id_lo[64], tag_id_hi[16],
  // tag_id_len[4], read_slot[3], zero fill[6].
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,
  // in_tuser: command.
  input  wire logic         in_tuser,
  // out_tdata, from bit 0: was_hit[1], was_inserted[1], out_valid[1], out_type[3],
  // out_id_lo[64], out_id_hi[16], out_id_len[4], out_last_seen[32], zero fill[6].
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_wdata
);

  localparam int ID_W  = ID_BYTES * 8;
  localparam int ENT_W = 3 + ID_W + 4 + 32;
  localparam int PH_W  = $clog2(TABLE_SLOTS);
  localparam int KW    = rtt_pkg::KEY_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AGE,
    ST_MATCH,
    ST_UPDATE,
    ST_KEY,
    ST_SORT,
    ST_OUT
  } state_t;

  state_t          state_r;
  logic [31:0]     limit_r;
  logic            cmd_r;
  logic [31:0]     now_r;
  logic [2:0]      type_r;
  logic [ID_W-1:0] id_r;
  logic [3:0]      len_r;
  logic [2:0]      slot_r;
  logic            hit_r;
  logic            ins_r;
  logic [PH_W-1:0] phase_r;
  logic            out_tvalid_r;
  logic [127:0]    out_tdata_r;

  rtt_pkg::cell_ctrl_t    ctrl;
  logic [ENT_W-1:0]       ent_a [TABLE_SLOTS];
  logic [KW-1:0]          key_a [TABLE_SLOTS];
  logic [TABLE_SLOTS-1:0] gt_a;
  logic [TABLE_SLOTS-1:0] match_vec;
  logic [TABLE_SLOTS-1:0] sel_vec;
  logic [ENT_W-1:0]       rd_ent;
  logic [3:0]             len_in;
  logic [79:0]            rd_id;
  logic [127:0]           result;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  // Lengths past the stored id width saturate.
  assign len_in = (in_tdata[118:115] > 4'(ID_BYTES)) ? 4'(ID_BYTES) : in_tdata[118:115];

  // Only the first matching slot is refreshed.
  assign sel_vec = match_vec & (~match_vec + TABLE_SLOTS'(1));

  // Broadcast control for the row of cells.
  always_comb begin
    ctrl.phase    = phase_r[0];
    ctrl.miss     = ~|match_vec;
    ctrl.now      = now_r;
    ctrl.limit    = limit_r;
    ctrl.tag_type = type_r;
    ctrl.tag_len  = len_r;
    unique case (state_r)
      ST_AGE:    ctrl.op = rtt_pkg::OP_AGE;
      ST_MATCH:  ctrl.op = rtt_pkg::OP_MATCH;
      ST_UPDATE: ctrl.op = rtt_pkg::OP_UPDATE;
      ST_KEY:    ctrl.op = rtt_pkg::OP_KEY;
      ST_SORT:   ctrl.op = rtt_pkg::OP_SORT;
      default:   ctrl.op = rtt_pkg::OP_HOLD;
    endcase
  end

  // Row of slot cells, each wired to its two neighbors.
  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_cell
    logic [ENT_W-1:0] prev_ent;
    logic [KW-1:0]    prev_key;
    logic             prev_gt;
    logic [ENT_W-1:0] next_ent;
    logic [KW-1:0]    next_key;

    if (i == 0) begin : g_first
      assign prev_ent = '0;
      assign prev_key = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_mid
      assign prev_ent = ent_a[i-1];
      assign prev_key = key_a[i-1];
      assign prev_gt  = gt_a[i-1];
    end

    if (i == TABLE_SLOTS - 1) begin : g_last
      assign next_ent = '0;
      assign next_key = '0;
    end else begin : g_inner
      assign next_ent = ent_a[i+1];
      assign next_key = key_a[i+1];
    end

    rtt_cell #(
      .ID_BYTES(ID_BYTES),
      .IDX(i),
      .SLOTS(TABLE_SLOTS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .tag_id  (id_r),
      .sel     (sel_vec[i]),
      .prev_ent(prev_ent),
      .prev_key(prev_key),
      .prev_gt (prev_gt),
      .next_ent(next_ent),
      .next_key(next_key),
      .ent     (ent_a[i]),
      .key     (key_a[i]),
      .gt_next (gt_a[i]),
      .match   (match_vec[i])
    );
  end

  // Read selection; a slot past the table end reads as zero.
  always_comb begin
    rd_ent = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (32'(slot_r) == i) begin
        rd_ent = rd_ent | ent_a[i];
      end
    end
  end

  assign rd_id = 80'(rd_ent[ID_W+2:3]);

  // Result word for the current command.
  always_comb begin
    result = '0;
    if (cmd_r) begin
      result[2]     = (rd_ent[ENT_W-1 -: 32] != 32'd0);
      result[5:3]   = rd_ent[2:0];
      result[69:6]  = rd_id[63:0];
      result[85:70] = rd_id[79:64];
      result[89:86] = rd_ent[ID_W+6:ID_W+3];
      result[121:90] = rd_ent[ENT_W-1 -: 32];
    end else begin
      result[0] = hit_r;
      result[1] = ins_r;
    end
  end

  // Age limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= rtt_pkg::AGE_LIMIT_RESET;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      phase_r      <= '0;
      hit_r        <= 1'b0;
      ins_r        <= 1'b0;
    end else begin
      // A new result takes the register when it is free or being handed over.
      if ((state_r == ST_OUT) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd_r   <= in_tuser;
            now_r   <= in_tdata[31:0];
            type_r  <= in_tdata[34:32];
            id_r    <= ID_W'(in_tdata[114:35]);
            len_r   <= len_in;
            slot_r  <= in_tdata[121:119];
            hit_r   <= 1'b0;
            ins_r   <= 1'b0;
            state_r <= in_tuser ? ST_OUT : ST_AGE;
          end
        end
        ST_AGE: begin
          state_r <= (len_r == 4'd0) ? ST_OUT : ST_MATCH;
        end
        ST_MATCH: begin
          state_r <= ST_UPDATE;
        end
        ST_UPDATE: begin
          hit_r   <= |match_vec;
          ins_r   <= ~|match_vec;
          state_r <= ST_KEY;
        end
        ST_KEY: begin
          phase_r <= '0;
          state_r <= ST_SORT;
        end
        ST_SORT: begin
          phase_r <= phase_r + PH_W'(1);
          if (phase_r == PH_W'(TABLE_SLOTS - 1)) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_tvalid_r || out_tready) begin
            out_tdata_r <= result;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> test/recent_tag_table_aging_tb.sv
// Self-checking testbench for the recent tag table with age expiry.
`timescale 1ns / 1ps

module recent_tag_table_aging_tb;

  localparam int TABLE_SLOTS = 8;
  localparam int ID_BYTES = 10;
  localparam int POOL_SIZE = 6;
  // Leave a margin after the longest detect before config writes.
  localparam int DRAIN_CYCLES = TABLE_SLOTS + 10;
  localparam int CYCLE_LIMIT = 400000;

  // Command codes carried on in_tuser.
  localparam logic CMD_DETECT = 1'b0;
  localparam logic CMD_READ = 1'b1;

  // One input transfer, packed as on in_tdata (lowest field last).
  typedef struct packed {
    logic [5:0]  fill;
    logic [2:0]  read_slot;
    logic [3:0]  id_len;
    logic [15:0] id_hi;
    logic [63:0] id_lo;
    logic [2:0]  tag_type;
    logic [31:0] now_ms;
  } rtt_item_t;

  // One result transfer, packed as on out_tdata.
  typedef struct packed {
    logic [5:0]  fill;
    logic [31:0] stamp_ms;
    logic [3:0]  id_len;
    logic [15:0] id_hi;
    logic [63:0] id_lo;
    logic [2:0]  tag_type;
    logic        entry_valid;
    logic        was_inserted;
    logic        was_hit;
  } rtt_result_t;

  // One table entry of the prediction.
  typedef struct packed {
    logic [2:0]  tag_type;
    logic [79:0] id;
    logic [3:0]  id_len;
    logic [31:0] stamp_ms;
  } tag_entry_t;

  logic         clk;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;
  logic         in_tuser = 1'b0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic         cfg_we = 1'b0;
  logic [31:0]  cfg_wdata = '0;

  // Predicted table contents and age limit.
  tag_entry_t  tag_table [TABLE_SLOTS];
  logic [31:0] age_limit = rtt_pkg::AGE_LIMIT_RESET;

  rtt_result_t pending_responses [$];

  // Pool of recurring tags so that detects hit often.
  logic [2:0]  pool_type [POOL_SIZE];
  logic [63:0] pool_lo [POOL_SIZE];
  logic [15:0] pool_hi [POOL_SIZE];
  logic [31:0] sim_now = 32'h100;

  bit quiet_mode = 1'b0;
  int rx_hold = 0;
  int mismatches = 0;
  int responses_seen = 0;
  int cycle_count = 0;
  int n_reads = 0;
  int n_hits = 0;
  int n_inserts = 0;
  int n_aging = 0;
  int n_settings = 0;

  recent_tag_table_aging #(
    .TABLE_SLOTS(TABLE_SLOTS),
    .ID_BYTES(ID_BYTES)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               pending_responses.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // True when entry a belongs behind entry b: empty entries last, then younger first.
  function automatic logic ranks_behind(tag_entry_t a, tag_entry_t b, logic [31:0] now);
    logic [31:0] age_a;
    logic [31:0] age_b;
    if (b.stamp_ms == 32'd0) return 1'b0;
    if (a.stamp_ms == 32'd0) return 1'b1;
    age_a = now - a.stamp_ms;
    age_b = now - b.stamp_ms;
    return age_a > age_b;
  endfunction

  // Applies one command to the predicted table and returns the response it causes.
  function automatic rtt_result_t table_response(logic cmd, rtt_item_t it);
    rtt_result_t res;
    tag_entry_t  ent;
    tag_entry_t  tmp;
    logic [79:0] id_in;
    logic [31:0] age;
    logic        matched;
    int          eff_len;
    int          hit_at;
    int          stop;
    int          last;
    res = '0;
    if (cmd == CMD_READ) begin
      if (int'(it.read_slot) < TABLE_SLOTS) begin
        ent = tag_table[it.read_slot];
        res.entry_valid = (ent.stamp_ms != 32'd0);
        res.tag_type = ent.tag_type;
        res.id_lo = ent.id[63:0];
        res.id_hi = ent.id[79:64];
        res.id_len = ent.id_len;
        res.stamp_ms = ent.stamp_ms;
      end
      return res;
    end

    // Aging runs on every detect, before the lookup.
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      age = it.now_ms - tag_table[i].stamp_ms;
      if (age > age_limit) tag_table[i] = '0;
    end

    eff_len = (int'(it.id_len) > ID_BYTES) ? ID_BYTES : int'(it.id_len);
    if (eff_len == 0) return res;
    id_in = {it.id_hi, it.id_lo};

    // First entry with equal type and equal leading bytes wins; empty ones count.
    hit_at = -1;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (hit_at < 0) begin
        ent = tag_table[i];
        matched = (ent.tag_type == it.tag_type);
        for (int b = 0; b < eff_len; b++) begin
          if (ent.id[8*b +: 8] != id_in[8*b +: 8]) matched = 1'b0;
        end
        if (matched) hit_at = i;
      end
    end

    if (hit_at >= 0) begin
      tag_table[hit_at].stamp_ms = it.now_ms;
    end else begin
      // A miss overwrites the last slot; bytes past the length stay as they were.
      ent = tag_table[TABLE_SLOTS-1];
      for (int b = 0; b < eff_len; b++) ent.id[8*b +: 8] = id_in[8*b +: 8];
      ent.id_len = 4'(eff_len);
      ent.tag_type = it.tag_type;
      ent.stamp_ms = it.now_ms;
      tag_table[TABLE_SLOTS-1] = ent;
    end

    // Stable bubble sort by age, youngest first.
    stop = TABLE_SLOTS;
    while (stop > 1) begin
      last = 0;
      for (int i = 1; i < stop; i++) begin
        if (ranks_behind(tag_table[i-1], tag_table[i], it.now_ms)) begin
          tmp = tag_table[i-1];
          tag_table[i-1] = tag_table[i];
          tag_table[i] = tmp;
          last = i;
        end
      end
      stop = last;
    end

    res.was_hit = (hit_at >= 0);
    res.was_inserted = (hit_at < 0);
    return res;
  endfunction

  function automatic rtt_item_t detect_item(logic [31:0] now, logic [2:0] kind,
                                            logic [63:0] lo, logic [15:0] hi,
                                            logic [3:0] len);
    rtt_item_t it;
    it.fill = '0;
    it.now_ms = now;
    it.tag_type = kind;
    it.id_lo = lo;
    it.id_hi = hi;
    it.id_len = len;
    it.read_slot = 3'($urandom);
    return it;
  endfunction

  // A read ignores every field but the slot, so the rest is random noise.
  function automatic rtt_item_t read_item(logic [2:0] slot);
    rtt_item_t it;
    it.fill = '0;
    it.now_ms = $urandom;
    it.tag_type = 3'($urandom);
    it.id_lo = {$urandom, $urandom};
    it.id_hi = 16'($urandom);
    it.id_len = 4'($urandom);
    it.read_slot = slot;
    return it;
  endfunction

  task automatic report_mismatch(input string what, input logic [127:0] got,
                                 input logic [127:0] want);
    mismatches++;
    $display("[%0t] response %0d: %s is %0h, predicted %0h", $time, responses_seen, what,
             got, want);
  endtask

  // Compares one result transfer with the oldest prediction.
  task automatic check_response(input logic [127:0] data);
    rtt_result_t got;
    rtt_result_t want;
    got = data;
    responses_seen++;
    if (pending_responses.size() == 0) begin
      report_mismatch("unexpected transfer", data, '0);
      return;
    end
    want = pending_responses.pop_front();
    if (got.was_hit !== want.was_hit)
      report_mismatch("was_hit", 128'(got.was_hit), 128'(want.was_hit));
    if (got.was_inserted !== want.was_inserted)
      report_mismatch("was_inserted", 128'(got.was_inserted), 128'(want.was_inserted));
    if (got.entry_valid !== want.entry_valid)
      report_mismatch("out_valid", 128'(got.entry_valid), 128'(want.entry_valid));
    if (got.tag_type !== want.tag_type)
      report_mismatch("out_type", 128'(got.tag_type), 128'(want.tag_type));
    if (got.id_lo !== want.id_lo)
      report_mismatch("out_id_lo", 128'(got.id_lo), 128'(want.id_lo));
    if (got.id_hi !== want.id_hi)
      report_mismatch("out_id_hi", 128'(got.id_hi), 128'(want.id_hi));
    if (got.id_len !== want.id_len)
      report_mismatch("out_id_len", 128'(got.id_len), 128'(want.id_len));
    if (got.stamp_ms !== want.stamp_ms)
      report_mismatch("out_last_seen", 128'(got.stamp_ms), 128'(want.stamp_ms));
  endtask

  // Offers one command after a random gap and predicts its response once accepted.
  task automatic send_command(input logic cmd, input rtt_item_t it);
    int          gap;
    rtt_result_t want;
    gap = quiet_mode ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= it;
    do @(posedge clk); while (!in_tready);
    want = table_response(cmd, it);
    pending_responses.push_back(want);
    if (cmd == CMD_READ) n_reads++;
    else if (want.was_hit) n_hits++;
    else if (want.was_inserted) n_inserts++;
    else n_aging++;
  endtask

  // Stops offering and waits until every predicted response has arrived.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_age_limit(input logic [31:0] limit);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    age_limit = limit;
    n_settings++;
  endtask

  // Draws a command: mostly detects of recurring tags at slowly advancing times.
  task automatic random_command(output logic cmd, output rtt_item_t it);
    int pick;
    int step_pick;
    int p;
    step_pick = $urandom_range(0, 99);
    if (step_pick < 20) sim_now = sim_now;
    else if (step_pick < 60) sim_now = sim_now + 32'($urandom_range(1, 300));
    else if (step_pick < 90) sim_now = sim_now + 32'($urandom_range(0, 20000));
    else sim_now = sim_now + $urandom;

    if ($urandom_range(0, 99) < 30) begin
      cmd = CMD_READ;
      it = read_item(3'($urandom_range(0, TABLE_SLOTS - 1)));
    end else begin
      cmd = CMD_DETECT;
      p = $urandom_range(0, POOL_SIZE - 1);
      if ($urandom_range(0, 19) == 0) begin
        pool_type[p] = 3'($urandom);
        pool_lo[p] = {$urandom, $urandom};
        pool_hi[p] = 16'($urandom);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55)
        it = detect_item(sim_now, pool_type[p], pool_lo[p], pool_hi[p],
                         4'($urandom_range(1, ID_BYTES)));
      else if (pick < 65)
        it = detect_item(sim_now, pool_type[p], pool_lo[p], pool_hi[p],
                         4'($urandom_range(ID_BYTES + 1, 15)));
      else if (pick < 75)
        it = detect_item(sim_now, 3'($urandom), pool_lo[p], pool_hi[p],
                         4'($urandom_range(1, 15)));
      else if (pick < 87)
        it = detect_item(sim_now, 3'($urandom), {$urandom, $urandom}, 16'($urandom),
                         4'($urandom_range(1, 15)));
      else
        it = detect_item(sim_now, 3'($urandom), {$urandom, $urandom}, 16'($urandom), 4'd0);
    end
  endtask

  task automatic test_directed_cases();
    // An empty table reads back as zeros.
    send_command(CMD_READ, read_item(3'd7));
    // Type 0 with a zero id matches an empty entry.
    send_command(CMD_DETECT, detect_item(32'd5, 3'd0, 64'd0, 16'd0, 4'd1));
    send_command(CMD_READ, read_item(3'd0));
    // Far in the future: the old entry expires; the long length saturates.
    send_command(CMD_DETECT, detect_item(32'hFFFF_FFF0, 3'd7, '1, '1, 4'd15));
    send_command(CMD_READ, read_item(3'd0));
    // Time wraps past zero and the same tag is refreshed.
    send_command(CMD_DETECT, detect_item(32'h10, 3'd7, '1, '1, 4'd10));
    // A short id that equals the leading bytes of a stored one is a hit.
    send_command(CMD_DETECT, detect_item(32'h18, 3'd7, 64'h00FF_FFFF, 16'h0, 4'd3));
    // A miss with two bytes only writes those two bytes.
    send_command(CMD_DETECT, detect_item(32'h20, 3'd3, 64'hA5A5_0000_0000_1234, 16'hC3C3,
                                         4'd2));
    send_command(CMD_READ, read_item(3'd1));
    // Length zero only ages the table.
    send_command(CMD_DETECT, detect_item(32'h30, 3'd0, 64'd0, 16'd0, 4'd0));
    // A detect at time zero writes an entry that counts as empty.
    send_command(CMD_DETECT, detect_item(32'h0, 3'd5, 64'h0123_4567_89AB_CDEF, 16'hFEDC,
                                         4'd4));
    send_command(CMD_READ, read_item(3'd7));
    send_command(CMD_DETECT, detect_item(32'h40, 3'd2, '1, '1, 4'd1));
    send_command(CMD_READ, read_item(3'd7));
    // With a zero limit every entry older than now expires.
    set_age_limit(32'd0);
    send_command(CMD_DETECT, detect_item(32'h40, 3'd2, 64'd0, 16'd0, 4'd0));
    send_command(CMD_READ, read_item(3'd0));
    send_command(CMD_DETECT, detect_item(32'h41, 3'd1, 64'h5555, 16'd0, 4'd0));
    send_command(CMD_READ, read_item(3'd0));
    // With the largest limit nothing ever expires.
    set_age_limit(32'hFFFF_FFFF);
    send_command(CMD_DETECT, detect_item(32'hFFFF_FFFF, 3'd6, 64'h8000_0000_0000_0001,
                                         16'h8001, 4'd10));
    send_command(CMD_DETECT, detect_item(32'h7FFF_FFFF, 3'd4, 64'h1, 16'h0, 4'd8));
    send_command(CMD_READ, read_item(3'd0));
    send_command(CMD_READ, read_item(3'd2));
    wait_idle();
  endtask

  task automatic run_phase(input logic [31:0] limit, input int n_items, input bit quiet_start);
    logic      cmd;
    rtt_item_t it;
    set_age_limit(limit);
    for (int k = 0; k < n_items; k++) begin
      quiet_mode = quiet_start && (k < 40);
      random_command(cmd, it);
      send_command(cmd, it);
    end
    quiet_mode = 1'b0;
  endtask

  task automatic test_age_limit_phases();
    for (int p = 0; p < POOL_SIZE; p++) begin
      pool_type[p] = 3'($urandom);
      pool_lo[p] = {$urandom, $urandom};
      pool_hi[p] = 16'($urandom);
    end
    run_phase(rtt_pkg::AGE_LIMIT_RESET, 90, 1'b0);
    run_phase(32'd0, 90, 1'b1);
    run_phase(32'hFFFF_FFFF, 90, 1'b0);
    run_phase(32'($urandom_range(200, 5000)), 90, 1'b0);
    run_phase($urandom, 90, 1'b0);
    wait_idle();
  endtask

  // The receiver stops for a long stretch while commands keep coming back to back.
  task automatic test_receiver_holdoff();
    logic      cmd;
    rtt_item_t it;
    quiet_mode = 1'b1;
    rx_hold = 300;
    for (int k = 0; k < 24; k++) begin
      random_command(cmd, it);
      send_command(cmd, it);
    end
    quiet_mode = 1'b0;
    wait_idle();
  endtask

  // Result side: random stalls, plus the long hold-off on request.
  initial begin : response_monitor
    int stall;
    bit got;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (rx_hold != 0) begin
        out_tready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = quiet_mode ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      got = 1'b0;
      do begin
        @(posedge clk);
        if (out_tvalid) begin
          check_response(out_tdata);
          got = 1'b1;
        end
      end while (!got && rx_hold == 0);
    end
  end

  initial begin
    for (int i = 0; i < TABLE_SLOTS; i++) tag_table[i] = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_age_limit_phases();
    test_receiver_holdoff();
    wait_idle();

    $display("Checked %0d responses: %0d hits, %0d inserts, %0d aging-only detects, %0d reads.",
             responses_seen, n_hits, n_inserts, n_aging, n_reads);
    $display("Ran %0d age limit settings with random gaps, stalls and one long receiver hold.",
             n_settings);
    if (mismatches == 0 && pending_responses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
